// ===== src/ffpea_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpea_pkg
// Shared types and constants of the first-fit page extent allocator.
// ----------------------------------------------------------------------------
package ffpea_pkg;

  localparam int MAX_EXTENTS_DEF = 64;
  localparam int TOTAL_PAGES_DEF = 65536;
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_SHIFT      = 12;
  localparam int NEED_W          = 18;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // commands broadcast along the extent chain
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_PUSH   = 3'd2,
    CMD_ROTATE = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_SPLIT  = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t        op;
    logic [15:0] start;
    logic [16:0] len;
  } chain_ctl_t;

endpackage

// ===== src/ffpea_if.sv =====
// ----------------------------------------------------------------------------
// ffpea_if
// Request and response channels of the allocator.
// ----------------------------------------------------------------------------
interface ffpea_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] base_page;
  logic [16:0] count_pages;
  logic [28:0] request_bytes;
  modport source (output valid, kind, base_page, count_pages, request_bytes, input ready);
  modport sink (input valid, kind, base_page, count_pages, request_bytes, output ready);
endinterface

interface ffpea_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] result_page;
  modport source (output valid, status, result_page, input ready);
  modport sink (input valid, status, result_page, output ready);
endinterface

// ===== src/ffpea_ram.sv =====
// ----------------------------------------------------------------------------
// ffpea_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffpea_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ffpea_cell.sv =====
// ----------------------------------------------------------------------------
// ffpea_cell
// One extent slot of the free list chain.
// ----------------------------------------------------------------------------
module ffpea_cell
  import ffpea_pkg::*;
#(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic        clk,
  input  chain_ctl_t  ctl,
  input  logic [CW-1:0] sel,
  input  logic [15:0] left_start,
  input  logic [16:0] left_len,
  input  logic [15:0] right_start,
  input  logic [16:0] right_len,
  output logic [15:0] start,
  output logic [16:0] len
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [15:0] start_next;
  logic [16:0] len_next;

  always_comb begin
    start_next = start;
    len_next   = len;
    case (ctl.op)
      CMD_APPEND: begin
        if (sel == MY_IDX) begin
          start_next = ctl.start;
          len_next   = ctl.len;
        end
      end
      CMD_PUSH: begin
        if (IDX == 0) begin
          start_next = ctl.start;
          len_next   = ctl.len;
        end else begin
          start_next = left_start;
          len_next   = left_len;
        end
      end
      CMD_ROTATE: begin
        start_next = right_start;
        len_next   = right_len;
      end
      CMD_REMOVE: begin
        if (MY_IDX >= sel) begin
          start_next = right_start;
          len_next   = right_len;
        end
      end
      CMD_SPLIT: begin
        if (IDX == 0) begin
          start_next = ctl.start;
          len_next   = ctl.len;
        end else if (MY_IDX <= sel) begin
          start_next = left_start;
          len_next   = left_len;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start <= start_next;
    len   <= len_next;
  end

endmodule

// ===== src/first_fit_page_extent_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_extent_allocator
// First-fit page allocator over an ordered list of free extents.
// ----------------------------------------------------------------------------
// usage:
// - req channel carries one item: kind (add, allocate, free), base page,
//   page count of an added region and byte size of an allocation
// - rsp channel returns exactly one item per request: status and start page
// - the free list lives in a chain of MAX_EXTENTS cells, head in cell 0;
//   every cell talks only to its neighbors
// - add finishes in the execute step, free adds a push step (one run-length
//   read), allocate a scan and a commit step: the scan rotates the whole
//   chain once past the head cell, comparing one extent per cycle
// - one item at a time; a new item is accepted once the previous one has been
//   handed to the output register, so a result may wait while the next works
// - run lengths sit in a TOTAL_PAGES deep RAM; after reset a clearing pass
//   writes one into every entry, and no item is accepted during that pass
// - a stalled receiver holds the result in the output register; the block
//   finishes the next item and then waits for the register to drain
// ----------------------------------------------------------------------------
module first_fit_page_extent_allocator
  import ffpea_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int TOTAL_PAGES = TOTAL_PAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  ffpea_req_if.sink   req,
  ffpea_rsp_if.source rsp
);

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int AW = $clog2(TOTAL_PAGES);
  localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_EXTENTS);
  localparam logic [IW-1:0] STEP_LAST = IW'(MAX_EXTENTS - 1);
  localparam logic [AW-1:0] CLR_LAST  = AW'(TOTAL_PAGES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SCAN, S_COMMIT, S_FREE, S_DONE
  } state_t;

  state_t      state;
  logic [CW-1:0] count;
  logic [AW-1:0] clr_addr;
  logic [IW-1:0] step;

  // latched request
  kind_t       kind;
  logic [15:0] base;
  logic [16:0] cnt;
  logic [NEED_W-1:0] need;
  logic        base_in;

  // search results
  logic        found;
  logic [CW-1:0] pos;
  logic [15:0] fs;
  logic [16:0] fl;

  // result holding before output register
  status_t     res_status;
  logic [15:0] res_page;

  logic        out_valid;
  status_t     out_status;
  logic [15:0] out_page;

  chain_ctl_t  ctl;
  logic [CW-1:0] sel;
  logic [15:0] cell_start [MAX_EXTENTS];
  logic [16:0] cell_len   [MAX_EXTENTS];

  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [16:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [16:0] ram_rdata;

  logic [29:0] bytes_up;
  logic        accept;
  logic        head_fits;
  logic        has_rem;
  logic        out_free;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign bytes_up = {1'b0, req.request_bytes} + 30'(PAGE_BYTES - 1);
  assign head_fits = ({1'b0, cell_len[0]} >= need) && (CW'(step) < count);
  assign has_rem  = ({1'b0, fl} > need);
  assign out_free = !out_valid || rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.result_page = out_page;

  // chain of extent cells, cell 0 is the list head
  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == MAX_EXTENTS - 1) ? 0 : i + 1;
    ffpea_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .sel         (sel),
      .left_start  (cell_start[L]),
      .left_len    (cell_len[L]),
      .right_start (cell_start[R]),
      .right_len   (cell_len[R]),
      .start       (cell_start[i]),
      .len         (cell_len[i])
    );
  end

  ffpea_ram #(.WIDTH(17), .DEPTH(TOTAL_PAGES), .AW(AW)) u_runlen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // chain command and run-length port
  always_comb begin
    ctl.op    = CMD_HOLD;
    ctl.start = base;
    ctl.len   = cnt;
    sel       = count;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = 17'd1;
    // keep reading the latched page so the data holds until it is used
    ram_raddr = AW'(base);
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = AW'(req.base_page);
      end
      S_EXEC: begin
        if (kind == KIND_ADD && count < CNT_MAX) begin
          ctl.op = CMD_APPEND;
        end
      end
      S_SCAN: begin
        ctl.op = CMD_ROTATE;
      end
      S_COMMIT: begin
        if (found) begin
          sel       = pos;
          ctl.start = fs + need[15:0];
          ctl.len   = fl - need[16:0];
          ctl.op    = has_rem ? CMD_SPLIT : CMD_REMOVE;
          ram_we    = (32'(fs) < TOTAL_PAGES);
          ram_waddr = AW'(fs);
          ram_wdata = need[16:0];
        end
      end
      S_FREE: begin
        ctl.op  = CMD_PUSH;
        ctl.len = base_in ? ram_rdata : 17'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      count     <= '0;
      clr_addr  <= '0;
      step      <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind    <= kind_t'(req.kind);
            base    <= req.base_page;
            cnt     <= req.count_pages;
            need    <= NEED_W'(bytes_up >> PAGE_SHIFT);
            base_in <= (32'(req.base_page) < TOTAL_PAGES);
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= ST_OK;
          res_page   <= '0;
          step       <= '0;
          found      <= 1'b0;
          state      <= S_DONE;
          case (kind)
            KIND_ADD: begin
              if (count < CNT_MAX) begin
                count <= count + CW'(1);
              end else begin
                res_status <= ST_FULL;
              end
            end
            KIND_ALLOC: state <= S_SCAN;
            KIND_FREE: begin
              // run length read was issued on accept, data is ready now
              if (count < CNT_MAX) begin
                state <= S_FREE;
              end else begin
                res_status <= ST_FULL;
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          // head cell holds list entry number step
          if (!found && head_fits) begin
            found <= 1'b1;
            pos   <= CW'(step);
            fs    <= cell_start[0];
            fl    <= cell_len[0];
          end
          step <= step + IW'(1);
          if (step == STEP_LAST) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (found) begin
            res_page <= fs;
            if (!has_rem) begin
              count <= count - CW'(1);
            end
          end else begin
            res_status <= ST_NOFIT;
          end
          state <= S_DONE;
        end
        S_FREE: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_page   <= res_page;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // list never grows past the chain
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("extent count beyond capacity");

  // a full rotation always ends in the commit step
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && step == STEP_LAST) |=> state == S_COMMIT)
    else $error("scan did not reach commit");

  // an exact fit shrinks the list by one
  a_exact_fit: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && found && !has_rem) |=> count == $past(count) - CW'(1))
    else $error("exact fit did not drop an extent");

  // no item is taken during the run-length clearing pass
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !accept && !out_valid)
    else $error("activity during clearing pass");

endmodule
